// ===== hw/rtl/cq_pkg.sv =====
package cq_pkg;

    // Default sizes
    localparam int DEF_MAX_GROUP_WIDTH = 64;
    localparam int DEF_COEF_WIDTH      = 24;
    localparam int GROUPS              = 16;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_DIRECTION   = 2'd0;
    localparam logic [1:0] REG_QUANT_STEP  = 2'd1;
    localparam logic [1:0] REG_GROUP_WIDTH = 2'd2;
    localparam logic [1:0] REG_POINT_COUNT = 2'd3;

    // Register reset values
    localparam logic        RST_DIRECTION   = 1'b0;
    localparam logic [6:0]  RST_QUANT_STEP  = 7'd0;
    localparam logic [6:0]  RST_GROUP_WIDTH = 7'd1;
    localparam logic [10:0] RST_POINT_COUNT = 11'd0;

    // Direction codes
    localparam logic DIR_QUANTIZE   = 1'b0;
    localparam logic DIR_DEQUANTIZE = 1'b1;

    // Quantizer rounding constant (half of Q14)
    localparam int Q14_ROUND = 8192;
    localparam int Q14_SHIFT = 14;

    // Zigzag position of each group inside the 4x4 grid
    localparam logic [3:0] SCAN_POS [16] = '{
        4'd0, 4'd4, 4'd1, 4'd2, 4'd5, 4'd8, 4'd12, 4'd9,
        4'd6, 4'd3, 4'd7, 4'd10, 4'd13, 4'd14, 4'd11, 4'd15
    };

    // Row/column norm kind and pairing into six norm classes
    localparam logic [1:0] NORM_KIND [4] = '{2'd0, 2'd1, 2'd0, 2'd2};
    localparam logic [2:0] NORM_PAIR [3][3] = '{
        '{3'd0, 3'd1, 3'd2},
        '{3'd1, 3'd3, 3'd4},
        '{3'd2, 3'd4, 3'd5}
    };

    // Rescale factors: level x norm class
    localparam logic [6:0] RESCALE_ROM [8][6] = '{
        '{7'd16, 7'd21, 7'd24, 7'd28, 7'd32, 7'd37},
        '{7'd17, 7'd23, 7'd26, 7'd31, 7'd35, 7'd40},
        '{7'd19, 7'd25, 7'd29, 7'd33, 7'd38, 7'd43},
        '{7'd21, 7'd28, 7'd31, 7'd36, 7'd42, 7'd47},
        '{7'd23, 7'd30, 7'd34, 7'd40, 7'd45, 7'd52},
        '{7'd25, 7'd33, 7'd37, 7'd43, 7'd49, 7'd56},
        '{7'd27, 7'd36, 7'd41, 7'd47, 7'd54, 7'd61},
        '{7'd29, 7'd39, 7'd44, 7'd52, 7'd59, 7'd67}
    };

    // Descale factors in Q14: floor((2^19 + f) / (2 f)) for each rescale entry
    localparam logic [14:0] DESCALE_ROM [8][6] = '{
        '{15'd16384, 15'd12483, 15'd10923, 15'd9362, 15'd8192, 15'd7085},
        '{15'd15420, 15'd11398, 15'd10082, 15'd8456, 15'd7490, 15'd6554},
        '{15'd13797, 15'd10486, 15'd9039,  15'd7944, 15'd6899, 15'd6096},
        '{15'd12483, 15'd9362,  15'd8456,  15'd7282, 15'd6242, 15'd5578},
        '{15'd11398, 15'd8738,  15'd7710,  15'd6554, 15'd5825, 15'd5041},
        '{15'd10486, 15'd7944,  15'd7085,  15'd6096, 15'd5350, 15'd4681},
        '{15'd9709,  15'd7282,  15'd6394,  15'd5578, 15'd4855, 15'd4297},
        '{15'd9039,  15'd6722,  15'd5958,  15'd5041, 15'd4443, 15'd3913}
    };

    // Per-transaction control carried from the input stage to the datapath
    typedef struct packed {
        logic        dir;
        logic [3:0]  shift;
        logic [14:0] fd;
        logic [6:0]  f;
        logic        empty;
        logic        last;
        logic        in_range;
        logic [10:0] pos_inc;
    } cq_ctrl_t;

    // Norm class of a group from its zigzag position
    function automatic logic [2:0] norm_class(input logic [3:0] grp);
        logic [3:0] pos;
        pos = SCAN_POS[grp];
        return NORM_PAIR[NORM_KIND[pos[1:0]]][NORM_KIND[pos[3:2]]];
    endfunction

endpackage

// ===== hw/rtl/coefficient_quantizer_unit.sv =====
// Channel   Direction  Handshake                  Payload
// coef      in         coef_valid / coef_stall    coefficient
// result    out        result_valid / result_stall value, block_end, significant_count
// config    in         APB psel/penable/pwrite    paddr, pwdata -> prdata
//
// One coefficient per cycle while coef_stall is low, through an input
// register (group factor lookup, block counters) and a result register
// (one multiply, then the dead-zone rounding shift or the dequantize scaling).
// Reset clears the block counters, both valid bits and the registers to their
// defaults (group_width 1, others 0).
// A stalled result holds in its register; the input register still takes one
// more transaction, then coef_stall rises until the result is taken.
module coefficient_quantizer_unit #(
    parameter int MAX_GROUP_WIDTH = cq_pkg::DEF_MAX_GROUP_WIDTH,
    parameter int COEF_WIDTH      = cq_pkg::DEF_COEF_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    input  logic                         coef_valid,
    output logic                         coef_stall,
    input  logic signed [COEF_WIDTH-1:0] coefficient,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [COEF_WIDTH-1:0] value,
    output logic                         block_end,
    output logic [10:0]                  significant_count
);

    localparam int GW_W  = ($clog2(MAX_GROUP_WIDTH + 1) > 7) ?
                           $clog2(MAX_GROUP_WIDTH + 1) : 7;
    localparam int LEN_W = GW_W + 4;
    localparam int CMP_W = (LEN_W > 12) ? LEN_W : 12;

    // Configuration registers
    logic        direction_reg;
    logic [6:0]  quant_step_reg;
    logic [6:0]  group_width_reg;
    logic [10:0] point_count_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= cq_pkg::RST_DIRECTION;
            quant_step_reg  <= cq_pkg::RST_QUANT_STEP;
            group_width_reg <= cq_pkg::RST_GROUP_WIDTH;
            point_count_reg <= cq_pkg::RST_POINT_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                cq_pkg::REG_DIRECTION:   direction_reg   <= pwdata[0];
                cq_pkg::REG_QUANT_STEP:  quant_step_reg  <= pwdata[6:0];
                cq_pkg::REG_GROUP_WIDTH: group_width_reg <= pwdata[6:0];
                cq_pkg::REG_POINT_COUNT: point_count_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            cq_pkg::REG_DIRECTION:   prdata = 32'(direction_reg);
            cq_pkg::REG_QUANT_STEP:  prdata = 32'(quant_step_reg);
            cq_pkg::REG_GROUP_WIDTH: prdata = 32'(group_width_reg);
            cq_pkg::REG_POINT_COUNT: prdata = 32'(point_count_reg);
            default:                 prdata = '0;
        endcase
    end

    // Pipeline handshake
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_next;
    logic out_load;
    logic in_accept;

    assign out_load   = s1_valid_reg && (!result_valid || !result_stall);
    assign coef_stall = s1_valid_reg && !out_load;
    assign in_accept  = coef_valid && !coef_stall;

    // Effective group width and block length
    logic [GW_W-1:0]  gw_raw;
    logic [GW_W-1:0]  gw_eff;
    logic [CMP_W-1:0] len_full;
    logic [CMP_W-1:0] blk_len;
    logic [CMP_W-1:0] pos_inc_wide;
    logic             blk_empty;
    logic             blk_last;

    logic [10:0] position_reg;
    logic [10:0] position_next;
    logic [3:0]  group_reg;
    logic [3:0]  group_next;
    logic [6:0]  igc_reg;
    logic [6:0]  igc_next;
    logic [6:0]  igc_inc;

    assign gw_raw = GW_W'(group_width_reg);

    always_comb
    begin
        if (gw_raw == '0)
        begin
            gw_eff = GW_W'(1);
        end
        else if (gw_raw > GW_W'(MAX_GROUP_WIDTH))
        begin
            gw_eff = GW_W'(MAX_GROUP_WIDTH);
        end
        else
        begin
            gw_eff = gw_raw;
        end
    end

    assign len_full = CMP_W'({gw_eff, 4'b0000});

    always_comb
    begin
        if (direction_reg == cq_pkg::DIR_DEQUANTIZE &&
            CMP_W'(point_count_reg) < len_full)
        begin
            blk_len = CMP_W'(point_count_reg);
        end
        else
        begin
            blk_len = len_full;
        end
    end

    assign pos_inc_wide = CMP_W'(position_reg) + CMP_W'(1);
    assign blk_empty    = (blk_len == '0);
    assign blk_last     = (pos_inc_wide >= blk_len);
    assign igc_inc      = igc_reg + 7'd1;

    // Block counters advance on each accepted transaction of a non-empty block
    always_comb
    begin
        position_next = position_reg;
        group_next    = group_reg;
        igc_next      = igc_reg;
        if (in_accept && !blk_empty)
        begin
            if (blk_last)
            begin
                position_next = '0;
                group_next    = '0;
                igc_next      = '0;
            end
            else
            begin
                position_next = pos_inc_wide[10:0];
                if (GW_W'(igc_inc) >= gw_eff)
                begin
                    igc_next   = '0;
                    group_next = group_reg + 4'd1;
                end
                else
                begin
                    igc_next = igc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            group_reg    <= '0;
            igc_reg      <= '0;
        end
        else
        begin
            position_reg <= position_next;
            group_reg    <= group_next;
            igc_reg      <= igc_next;
        end
    end

    // Input stage: factor lookup and per-transaction control
    cq_pkg::cq_ctrl_t            ctrl_in;
    cq_pkg::cq_ctrl_t            s1_ctrl_reg;
    logic signed [COEF_WIDTH-1:0] s1_coef_reg;
    logic [2:0]                  grp_class;

    assign grp_class = cq_pkg::norm_class(group_reg);

    always_comb
    begin
        ctrl_in.dir      = direction_reg;
        ctrl_in.shift    = quant_step_reg[6:3];
        ctrl_in.fd       = cq_pkg::DESCALE_ROM[quant_step_reg[2:0]][grp_class];
        ctrl_in.f        = cq_pkg::RESCALE_ROM[quant_step_reg[2:0]][grp_class];
        ctrl_in.empty    = blk_empty;
        ctrl_in.last     = blk_last;
        ctrl_in.in_range = (position_reg < point_count_reg);
        ctrl_in.pos_inc  = pos_inc_wide[10:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ctrl_reg <= ctrl_in;
            s1_coef_reg <= coefficient;
        end
    end

    // Arithmetic
    logic signed [COEF_WIDTH-1:0] value_calc;

    cq_datapath #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_datapath (
        .ctrl  (s1_ctrl_reg),
        .coef  (s1_coef_reg),
        .value (value_calc)
    );

    // Last significant position, tracked as results enter the output register
    logic [10:0] last_sig_reg;
    logic [10:0] last_sig_next;
    logic [10:0] last_sig_cur;
    logic        sig_hit;
    logic        quant_end;

    assign sig_hit   = (s1_ctrl_reg.dir == cq_pkg::DIR_QUANTIZE) && !s1_ctrl_reg.empty &&
                       s1_ctrl_reg.in_range && (value_calc != '0);
    assign last_sig_cur = sig_hit ? s1_ctrl_reg.pos_inc : last_sig_reg;
    assign quant_end = (s1_ctrl_reg.dir == cq_pkg::DIR_QUANTIZE) && !s1_ctrl_reg.empty &&
                       s1_ctrl_reg.last;

    always_comb
    begin
        last_sig_next = last_sig_reg;
        if (out_load && !s1_ctrl_reg.empty)
        begin
            last_sig_next = s1_ctrl_reg.last ? 11'd0 : last_sig_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sig_reg <= '0;
        end
        else
        begin
            last_sig_reg <= last_sig_next;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = result_valid;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_valid && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value             <= value_calc;
            block_end         <= s1_ctrl_reg.empty || s1_ctrl_reg.last;
            significant_count <= quant_end ? last_sig_cur : 11'd0;
        end
    end

    // Checks
    a_sig_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !block_end |-> significant_count == 11'd0)
        else $error("significant_count set on a non-final result");

    a_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && blk_last && !blk_empty |=>
            position_reg == 11'd0 && group_reg == 4'd0 && igc_reg == 7'd0)
        else $error("block counters not cleared after final coefficient");

    a_last_sig_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && s1_ctrl_reg.last && !s1_ctrl_reg.empty |=> last_sig_reg == 11'd0)
        else $error("last significant position kept across blocks");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result_valid && result_stall |-> coef_stall)
        else $error("input taken while both stages are full");

endmodule

// ===== hw/rtl/cq_datapath.sv =====
module cq_datapath #(
    parameter int COEF_WIDTH = cq_pkg::DEF_COEF_WIDTH
) (
    input  cq_pkg::cq_ctrl_t              ctrl,
    input  logic signed [COEF_WIDTH-1:0]  coef,
    output logic signed [COEF_WIDTH-1:0]  value
);

    localparam int QPW = COEF_WIDTH + 16;   // quantizer product
    localparam int PW  = QPW - cq_pkg::Q14_SHIFT;
    localparam int SW  = PW + 1;            // after dead-zone bias

    // Quantize: rounded Q14 multiply
    logic signed [QPW-1:0] coef_ext;
    logic signed [QPW-1:0] fd_ext;
    logic signed [QPW-1:0] prod_q;
    logic signed [QPW-1:0] prod_rnd;
    logic signed [PW-1:0]  p_val;

    assign coef_ext = QPW'(coef);
    assign fd_ext   = QPW'($signed({1'b0, ctrl.fd}));
    assign prod_q   = coef_ext * fd_ext;
    assign prod_rnd = prod_q + QPW'(cq_pkg::Q14_ROUND);
    assign p_val    = prod_rnd[QPW-1:cq_pkg::Q14_SHIFT];

    // Dead-zone bias, symmetric about zero
    logic [16:0]           scale;
    logic [15:0]           half;
    logic [15:0]           dz;
    logic [15:0]           bias_pos;
    logic [15:0]           bias_neg;
    logic [15:0]           bias;
    logic signed [SW-1:0]  p_adj;
    logic signed [SW-1:0]  q_shr;

    assign scale    = 17'(1) << ctrl.shift;
    assign half     = scale[16:1];
    assign dz       = (ctrl.shift >= 4'd4) ? (16'(1) << (ctrl.shift - 4'd4)) : 16'd0;
    assign bias_pos = half - dz;
    assign bias_neg = scale[15:0] - 16'd1 - bias_pos;
    assign bias     = p_val[PW-1] ? bias_neg : bias_pos;
    assign p_adj    = SW'(p_val) + SW'($signed({1'b0, bias}));
    assign q_shr    = p_adj >>> ctrl.shift;

    // Dequantize: 16-bit multiply and scale, wrapped to 16 bits
    logic signed [15:0] x16;
    logic signed [23:0] prod_d;
    logic signed [23:0] d_shr;
    logic [15:0]        d_shl;
    logic [15:0]        d_val;

    assign x16    = $signed(coef[15:0]);
    assign prod_d = 24'(x16) * 24'($signed({1'b0, ctrl.f}));
    assign d_shr  = prod_d >>> (3'd4 - {1'b0, ctrl.shift[1:0]});
    assign d_shl  = prod_d[15:0] << (ctrl.shift - 4'd4);
    assign d_val  = (ctrl.shift < 4'd4) ? d_shr[15:0] : d_shl;

    // Result select
    always_comb
    begin
        if (ctrl.empty)
        begin
            value = '0;
        end
        else if (ctrl.dir == cq_pkg::DIR_DEQUANTIZE)
        begin
            value = COEF_WIDTH'($signed(d_val));
        end
        else
        begin
            value = q_shr[COEF_WIDTH-1:0];
        end
    end

endmodule

// ===== test/tb_coefficient_quantizer_unit.sv =====
`timescale 1ns / 100ps

module tb_coefficient_quantizer_unit;

    localparam int CW           = cq_pkg::DEF_COEF_WIDTH;
    localparam int WIDTH_LIMIT  = cq_pkg::DEF_MAX_GROUP_WIDTH;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_ITEMS   = 200;
    localparam int PRINT_LIMIT  = 30;

    // Zigzag position of each group and the step table (level x norm class)
    localparam logic [3:0] ZIGZAG [16] = '{
        4'd0, 4'd4, 4'd1, 4'd2, 4'd5, 4'd8, 4'd12, 4'd9,
        4'd6, 4'd3, 4'd7, 4'd10, 4'd13, 4'd14, 4'd11, 4'd15
    };
    localparam logic [6:0] STEP_SCALE [8][6] = '{
        '{7'd16, 7'd21, 7'd24, 7'd28, 7'd32, 7'd37},
        '{7'd17, 7'd23, 7'd26, 7'd31, 7'd35, 7'd40},
        '{7'd19, 7'd25, 7'd29, 7'd33, 7'd38, 7'd43},
        '{7'd21, 7'd28, 7'd31, 7'd36, 7'd42, 7'd47},
        '{7'd23, 7'd30, 7'd34, 7'd40, 7'd45, 7'd52},
        '{7'd25, 7'd33, 7'd37, 7'd43, 7'd49, 7'd56},
        '{7'd27, 7'd36, 7'd41, 7'd47, 7'd54, 7'd61},
        '{7'd29, 7'd39, 7'd44, 7'd52, 7'd59, 7'd67}
    };

    // One output transaction as the block should deliver it
    typedef struct packed {
        logic [CW-1:0] value;
        logic          block_end;
        logic [10:0]   significant_count;
    } level_t;

    // DUT ports
    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          psel         = 1'b0;
    logic          penable      = 1'b0;
    logic          pwrite       = 1'b0;
    logic [3:0]    paddr        = '0;
    logic [31:0]   pwdata       = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          coef_valid   = 1'b0;
    logic          coef_stall;
    logic [CW-1:0] coefficient  = '0;
    logic          result_valid;
    logic          result_stall = 1'b0;
    logic [CW-1:0] value;
    logic          block_end;
    logic [10:0]   significant_count;

    // Register copies and block counters of the predictor
    logic        cfg_dir      = cq_pkg::RST_DIRECTION;
    logic [6:0]  cfg_step     = cq_pkg::RST_QUANT_STEP;
    logic [6:0]  cfg_width    = cq_pkg::RST_GROUP_WIDTH;
    logic [10:0] cfg_points   = cq_pkg::RST_POINT_COUNT;
    logic [10:0] blk_pos      = '0;
    logic [3:0]  blk_group    = '0;
    logic [6:0]  blk_fill     = '0;
    logic [10:0] blk_last_sig = '0;

    level_t expected_levels [$];
    int     coef_count   = 0;
    int     result_count = 0;
    int     block_count  = 0;
    int     setting_count = 0;
    int     errors       = 0;
    int     stall_left   = 0;
    bit     calm         = 1'b0;

    coefficient_quantizer_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .coef_valid        (coef_valid),
        .coef_stall        (coef_stall),
        .coefficient       (coefficient),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .value             (value),
        .block_end         (block_end),
        .significant_count (significant_count)
    );

    always #4 clk = ~clk;

    // Hard stop in case the handshake hangs
    initial
    begin
        #5_000_000;
        $display("tb_coefficient_quantizer_unit: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Group width as the block uses it
    function automatic int unsigned effective_width();
        int unsigned gw;
        gw = 32'(cfg_width);
        if (gw == 0)
            gw = 1;
        if (gw > WIDTH_LIMIT)
            gw = WIDTH_LIMIT;
        return gw;
    endfunction

    function automatic int unsigned block_length();
        int unsigned len;
        len = cq_pkg::GROUPS * effective_width();
        if (cfg_dir == cq_pkg::DIR_DEQUANTIZE && 32'(cfg_points) < len)
            len = 32'(cfg_points);
        return len;
    endfunction

    // Step factor of a group: axis kinds 0,1,0,2 pair up into six classes
    function automatic longint group_factor(input logic [3:0] grp, input logic [2:0] lvl);
        logic [3:0] pos;
        logic [1:0] ka, kb;
        logic [2:0] cls;
        pos = ZIGZAG[grp];
        ka = (pos[1:0] == 2'd1) ? 2'd1 : (pos[1:0] == 2'd3) ? 2'd2 : 2'd0;
        kb = (pos[3:2] == 2'd1) ? 2'd1 : (pos[3:2] == 2'd3) ? 2'd2 : 2'd0;
        if (ka == 2'd0)
            cls = {1'b0, kb};
        else if (kb == 2'd0)
            cls = {1'b0, ka};
        else if (ka == kb)
            cls = (ka == 2'd1) ? 3'd3 : 3'd5;
        else
            cls = 3'd4;
        return longint'(STEP_SCALE[lvl][cls]);
    endfunction

    // Predict the output of one accepted coefficient and advance the block
    task automatic quantize_coef(input logic [CW-1:0] c);
        int unsigned gw, len, shift;
        longint      f, fd, x, p, scale, rb, v;
        logic        last;
        level_t      r;
        gw = effective_width();
        len = block_length();
        if (len == 0)
        begin
            r.value = '0;
            r.block_end = 1'b1;
            r.significant_count = '0;
            expected_levels.push_back(r);
            return;
        end
        shift = 32'(cfg_step[6:3]);
        f = group_factor(blk_group, cfg_step[2:0]);
        if (cfg_dir == cq_pkg::DIR_QUANTIZE)
        begin
            // rounded Q14 multiply, then dead-zone shift symmetric about zero
            scale = longint'(1) << shift;
            rb = (scale >>> 1) - ((shift >= 4) ? (longint'(1) << (shift - 4)) : longint'(0));
            fd = (longint'(524288) + f) / (2 * f);
            x = longint'($signed(c));
            p = (x * fd + 8192) >>> 14;
            if (p >= 0)
                p = p + rb;
            else
                p = p + scale - 1 - rb;
            v = p >>> shift;
            if (v != 0 && blk_pos < cfg_points)
                blk_last_sig = blk_pos + 11'd1;
        end
        else
        begin
            // low 16 bits times the step factor, scaled by 2^(shift-4), wrapped back to 16 bits
            x = longint'($signed(c[15:0]));
            if (shift < 4)
                p = (x * f) >>> (4 - shift);
            else
                p = (x * f) << (shift - 4);
            v = longint'($signed(p[15:0]));
        end
        last = (int'(blk_pos) + 1) >= int'(len);
        r.value = v[CW-1:0];
        r.block_end = last;
        r.significant_count = (last && cfg_dir == cq_pkg::DIR_QUANTIZE) ? blk_last_sig : 11'd0;
        expected_levels.push_back(r);
        if (last)
        begin
            blk_pos = '0;
            blk_group = '0;
            blk_fill = '0;
            blk_last_sig = '0;
        end
        else
        begin
            blk_pos = blk_pos + 11'd1;
            blk_fill = blk_fill + 7'd1;
            if (32'(blk_fill) >= gw)
            begin
                blk_fill = '0;
                blk_group = blk_group + 4'd1;
            end
        end
    endtask

    // Drive one coefficient transaction, with an occasional gap ahead of it
    task automatic send_coefficient(input logic [CW-1:0] c);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            coef_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        coef_valid <= 1'b1;
        coefficient <= c;
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        quantize_coef(c);
        coef_count++;
    endtask

    // Stop the input and wait until every pending result is out
    task automatic drain_results();
        coef_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cq_pkg::REG_DIRECTION:   cfg_dir = data[0];
            cq_pkg::REG_QUANT_STEP:  cfg_step = data[6:0];
            cq_pkg::REG_GROUP_WIDTH: cfg_width = data[6:0];
            cq_pkg::REG_POINT_COUNT: cfg_points = data[10:0];
        endcase
    endtask

    task automatic configure(input logic dir, input logic [6:0] step,
                             input logic [6:0] width, input logic [10:0] points);
        drain_results();
        write_register(cq_pkg::REG_DIRECTION, 32'(dir));
        write_register(cq_pkg::REG_QUANT_STEP, 32'(step));
        write_register(cq_pkg::REG_GROUP_WIDTH, 32'(width));
        write_register(cq_pkg::REG_POINT_COUNT, 32'(points));
        setting_count++;
    endtask

    function automatic logic [CW-1:0] random_coefficient();
        logic [31:0]   r;
        logic [CW-1:0] c;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1: c = r[CW-1:0];
            2: c = CW'(int'($urandom_range(0, 600)) - 300);
            3:
            begin
                c = r[CW-1:0] >> $urandom_range(1, CW - 1);
                if (r[31])
                    c = -c;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0: c = {1'b0, {(CW-1){1'b1}}};
                    1: c = {1'b1, {(CW-1){1'b0}}};
                    2: c = '0;
                    default: c = '1;
                endcase
            end
            default:
            begin
                // 16-bit edges under random upper bits
                c = r[CW-1:0];
                c[15:0] = r[31] ? 16'h7FFF : 16'h8000;
            end
        endcase
        return c;
    endfunction

    // Receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                result_stall <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(0, 11) == 0)
        begin
            stall_left <= int'($urandom_range(1, 15));
            result_stall <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        level_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            result_count++;
            if (expected_levels.size() == 0)
                report_mismatch($sformatf("result %0d with nothing pending", result_count));
            else
            begin
                want = expected_levels.pop_front();
                if (want.block_end)
                    block_count++;
                if (value !== want.value)
                    report_mismatch($sformatf("result %0d value %0d, expected %0d",
                        result_count, $signed(value), $signed(want.value)));
                if (block_end !== want.block_end)
                    report_mismatch($sformatf("result %0d block_end %b, expected %b",
                        result_count, block_end, want.block_end));
                if (significant_count !== want.significant_count)
                    report_mismatch($sformatf("result %0d significant_count %0d, expected %0d",
                        result_count, significant_count, want.significant_count));
            end
        end
    end

    // Defaults after reset, then a half block left open
    task automatic test_reset_state();
        send_coefficient(24'h7FFFFF);
        send_coefficient(24'h800000);
        send_coefficient(24'h000000);
        send_coefficient(24'h000001);
        send_coefficient(24'hFFFFFF);
        send_coefficient(24'h000002);
        send_coefficient(24'hFFFFFE);
        send_coefficient(24'h000003);
    endtask

    // Largest step, width 0 acting as 1, finishing the open block
    task automatic test_quantize_extremes();
        configure(cq_pkg::DIR_QUANTIZE, 7'd127, 7'd0, 11'd16);
        send_coefficient(24'h7FFFFF);
        send_coefficient(24'h800000);
        send_coefficient(24'd33000);
        send_coefficient(-24'sd33000);
        send_coefficient(24'd40000);
        send_coefficient(-24'sd40000);
        send_coefficient(24'h000000);
        send_coefficient(24'h400000);
    endtask

    // Empty block, wrap in 16 bits, length shrunk under an open block
    task automatic test_dequantize_special();
        configure(cq_pkg::DIR_DEQUANTIZE, 7'd0, 7'd127, 11'd0);
        send_coefficient(24'h7FFFFF);
        send_coefficient(24'h800000);
        configure(cq_pkg::DIR_DEQUANTIZE, 7'd127, 7'd127, 11'd5);
        send_coefficient(24'h007FFF);
        send_coefficient(24'hFF8000);
        send_coefficient(24'hA5FFFF);
        configure(cq_pkg::DIR_DEQUANTIZE, 7'd3, 7'd127, 11'd2);
        send_coefficient(24'h123456);
        configure(cq_pkg::DIR_DEQUANTIZE, 7'h20, 7'd1, 11'd2047);
        send_coefficient(24'h007FFF);
        send_coefficient(24'h008000);
        send_coefficient(24'h000001);
        send_coefficient(24'h5AFFFF);
    endtask

    // Random settings, mostly whole blocks of random coefficients
    task automatic test_random_mix();
        int          target, n;
        int unsigned len, pick;
        logic        dir;
        logic [6:0]  step, width;
        logic [10:0] points;
        target = coef_count + RANDOM_ITEMS;
        while (coef_count < target)
        begin
            dir = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            step = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 19);
            if (pick < 12)
                width = 7'($urandom_range(1, 4));
            else if (pick < 14)
                width = 7'($urandom_range(5, 16));
            else if (pick < 16)
                width = 7'd0;
            else if (pick == 16)
                width = 7'd64;
            else if (pick == 17)
                width = 7'($urandom_range(65, 127));
            else
                width = 7'($urandom_range(17, 63));
            pick = $urandom_range(0, 9);
            if (pick < 5)
                points = 11'($urandom_range(0, 40));
            else if (pick == 5)
                points = 11'd0;
            else if (pick == 6)
                points = 11'd2047;
            else
                points = 11'($urandom_range(0, 2047));
            configure(dir, step, width, points);

            len = block_length();
            if (len == 0)
                n = int'($urandom_range(1, 6));
            else if ($urandom_range(0, 9) < 7 && len > 32'(blk_pos))
                n = int'(len) - int'(blk_pos) +
                    (($urandom_range(0, 2) == 0) ? int'(len) : 0);
            else
                n = int'($urandom_range(1, 120));
            if (n > 1024)
                n = 1024;
            if (n > target - coef_count)
                n = target - coef_count;
            for (int i = 0; i < n; i++)
            begin
                if (coef_count >= target - CALM_ITEMS)
                    calm = 1'b1;
                send_coefficient(random_coefficient());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_quantize_extremes();
        test_dequantize_special();
        test_random_mix();
        drain_results();

        $display("covered %0d coefficients, %0d results, %0d blocks over %0d settings",
            coef_count, result_count, block_count, setting_count);
        $display("both directions, all step levels and shifts, widths 0 to 127; %0d mismatches",
            errors);
        if (errors == 0 && expected_levels.size() == 0)
            $display("tb_coefficient_quantizer_unit: done, clean");
        else
            $display("tb_coefficient_quantizer_unit: done, errors");
        $finish;
    end

endmodule
